@@ hdl/sc2a_pkg.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// sc2a_pkg
// Shared types, scancode constants and key tables for the set 1 decoder.
// ---------------------------------------------------------------------------
package sc2a_pkg;

	// Modifier scancodes (set 1)
	localparam logic [7:0] SC_LSHIFT_MAKE  = 8'h2A;
	localparam logic [7:0] SC_RSHIFT_MAKE  = 8'h36;
	localparam logic [7:0] SC_LSHIFT_BREAK = 8'hAA;
	localparam logic [7:0] SC_RSHIFT_BREAK = 8'hB6;
	localparam logic [7:0] SC_CTRL_MAKE    = 8'h1D;
	localparam logic [7:0] SC_CTRL_BREAK   = 8'h9D;

	// Number of keys covered by the tables
	localparam int unsigned KEY_COUNT = 58;

	// ASCII bounds used by the ctrl-letter mapping
	localparam logic [6:0] ASCII_LOWER_A = 7'h61;
	localparam logic [6:0] ASCII_LOWER_Z = 7'h7A;

	// US layout, no modifier
	localparam logic [6:0] PLAIN_MAP [0:KEY_COUNT-1] = '{
		7'h00, 7'h00, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38,
		7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09, 7'h71, 7'h77, 7'h65, 7'h72,
		7'h74, 7'h79, 7'h75, 7'h69, 7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h00,
		7'h61, 7'h73, 7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
		7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76, 7'h62, 7'h6E,
		7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h2A, 7'h00, 7'h20
	};

	// US layout, shift held
	localparam logic [6:0] SHIFTED_MAP [0:KEY_COUNT-1] = '{
		7'h00, 7'h00, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E, 7'h26, 7'h2A,
		7'h28, 7'h29, 7'h5F, 7'h2B, 7'h08, 7'h09, 7'h51, 7'h57, 7'h45, 7'h52,
		7'h54, 7'h59, 7'h55, 7'h49, 7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0A, 7'h00,
		7'h41, 7'h53, 7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3A,
		7'h22, 7'h7E, 7'h00, 7'h7C, 7'h5A, 7'h58, 7'h43, 7'h56, 7'h42, 7'h4E,
		7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h2A, 7'h00, 7'h20
	};

	// Modifier flags
	typedef struct packed {
		logic shift;
		logic ctrl;
	} sc2a_mods_t;

	// Decode result for one scancode
	typedef struct packed {
		sc2a_mods_t mods;
		logic       char_valid;
		logic [6:0] char_code;
	} sc2a_dec_t;

endpackage : sc2a_pkg
`default_nettype wire

@@ hdl/sc2a_decode.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// sc2a_decode
// Combinational decode of one scancode byte against the current modifier
// flags: returns updated flags and an optional ASCII character.
// ---------------------------------------------------------------------------
module sc2a_decode
	import sc2a_pkg::*;
(
	input  wire logic [7:0] code,
	input  wire sc2a_mods_t mods,
	output sc2a_dec_t       dec
);

	logic       in_table;
	logic [5:0] idx;
	logic [6:0] plain_ch;
	logic [6:0] shift_ch;
	logic [6:0] ctrl_ch;
	logic       is_letter;
	logic [6:0] ch;

	// Table lookup, only for make codes below the table size
	assign in_table = (code[7:6] == 2'b00) && (code[5:0] < 6'(KEY_COUNT));
	assign idx      = in_table ? code[5:0] : 6'd0;
	assign plain_ch = PLAIN_MAP[idx];
	assign shift_ch = SHIFTED_MAP[idx];

	// Ctrl + letter gives control code 1..26 (plain table holds lowercase)
	assign is_letter = (plain_ch >= ASCII_LOWER_A) && (plain_ch <= ASCII_LOWER_Z);
	assign ctrl_ch   = {2'b00, plain_ch[4:0]};

	always_comb begin
		if (mods.ctrl && !mods.shift && is_letter) begin
			ch = ctrl_ch;
		end else if (mods.shift) begin
			ch = shift_ch;
		end else begin
			ch = plain_ch;
		end
	end

	// Modifier tracking and result qualification
	always_comb begin
		dec.mods       = mods;
		dec.char_valid = 1'b0;
		dec.char_code  = ch;
		priority if (code == SC_LSHIFT_MAKE || code == SC_RSHIFT_MAKE) begin
			dec.mods.shift = 1'b1;
		end else if (code == SC_LSHIFT_BREAK || code == SC_RSHIFT_BREAK) begin
			dec.mods.shift = 1'b0;
		end else if (code == SC_CTRL_MAKE) begin
			dec.mods.ctrl = 1'b1;
		end else if (code == SC_CTRL_BREAK) begin
			dec.mods.ctrl = 1'b0;
		end else if (in_table) begin
			dec.char_valid = (ch != 7'd0);
		end else begin
			dec.char_valid = 1'b0;
		end
	end

endmodule : sc2a_decode
`default_nettype wire

@@ hdl/scancode_to_ascii_decoder_top.sv @@
// Path: input register, combinational decode, then the output register.
// Throughput: one scancode per cycle unless a character waits on a blocked
// output; both stages advance together, and non-character bytes never wait.
// Reset: arst_n asynchronously clears both pipeline valids and the shift and
// ctrl flags.
`default_nettype none
// ---------------------------------------------------------------------------
// scancode_to_ascii_decoder_top
// Set 1 keyboard scancode to ASCII decoder with shift/ctrl tracking.
// ---------------------------------------------------------------------------
module scancode_to_ascii_decoder_top
	import sc2a_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] scan_byte,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [6:0]      character
);

	logic       valid_s1;
	logic [7:0] code_s1;
	sc2a_mods_t mods_q;
	sc2a_dec_t  dec;
	logic       advance;
	logic       out_valid_q;
	logic [6:0] char_q;

	sc2a_decode u_decode (
		.code (code_s1),
		.mods (mods_q),
		.dec  (dec)
	);

	// Stage 1 moves on unless it holds a character and the output is blocked
	assign advance  = valid_s1 && (!dec.char_valid || !out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			code_s1 <= scan_byte;
		end
	end

	// Modifier flags, updated as each byte leaves stage 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mods_q <= '0;
		end else if (advance) begin
			mods_q <= dec.mods;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && dec.char_valid) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && dec.char_valid) begin
			char_q <= dec.char_code;
		end
	end

	assign out_valid = out_valid_q;
	assign character = char_q;

endmodule : scancode_to_ascii_decoder_top
`default_nettype wire

@@ hdl/sc2a_checker.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// sc2a_checker
// Port-level checks for the scancode decoder, bound to the top level.
// ---------------------------------------------------------------------------
module sc2a_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_valid,
	input wire logic       in_ready,
	input wire logic [7:0] scan_byte,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic [6:0] character
);

	// A delivered character is never NUL
	a_char_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> character != 7'd0)
		else $error("character transaction carries zero");

	// Input only stalls while a character is held on a blocked output
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (out_valid && !out_ready))
		else $error("input stalled without output backpressure");

	// Stalled scancode stays offered with the same byte
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid && $stable(scan_byte))
		else $error("scancode transaction changed while stalled");

	// Stalled result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("out_valid dropped before transaction");

	// Stalled result keeps its value
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(character))
		else $error("character changed while stalled");

endmodule : sc2a_checker

bind scancode_to_ascii_decoder_top sc2a_checker u_sc2a_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.scan_byte (scan_byte),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.character (character)
);
`default_nettype wire
